// ----- design/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Escape phase of the front classifier.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,  // nothing held
    PH_PCT   = 2'd1,  // a percent sign is held
    PH_DIGIT = 2'd2   // a percent sign and one hex digit are held
  } upd_phase_t;

  // One command: up to three bytes to send, lowest index first.
  typedef struct packed {
    logic            last;   // the final byte of this command ends the string
    logic [1:0]      cnt;    // number of valid bytes, 1 to 3
    logic [2:0][7:0] data;   // bytes in send order, data[0] first
  } upd_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // Value of a character already known to be a hex digit.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

// ----- design/url_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL form decoder: percent escapes and plus signs to bytes.
// ----------------------------------------------------------------------------
// One encoded character enters per transfer, with in_tlast on the final
// character of a string. A percent sign followed by two hex digits of either
// case becomes one byte, a plus sign becomes a space, and every other
// character passes through. A broken escape sends the held percent sign and
// any held digit as they are, and the breaking character is then decoded
// afresh. At the end of a string anything still held is flushed and the last
// decoded byte carries out_tlast. The input side takes one character per
// cycle as long as the four-entry command queue has room; the output side
// sends one byte per cycle while out_tready is high and commands wait, so a
// character that yields two or three bytes (a broken escape or an
// end-of-string flush) holds the output for each byte in turn and the queue
// absorbs the difference. A character's first output byte reaches out_tvalid
// by way of the queue, the back stage's command register and the registered
// output stage, in that order.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_char
  input  logic       in_tlast,    // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // out_last
);
  import upd_pkg::*;

  logic     in_acc;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  upd_cmd_t wr_cmd;
  upd_cmd_t rd_cmd;

  // The front always produces at most one command per character, so it can
  // take a character whenever the queue has a free slot.
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  // Front: escape tracking and classification of each character.
  upd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .char_i (in_tdata),
    .last_i (in_tlast),
    .push   (push),
    .cmd    (wr_cmd)
  );

  // Queue of pending commands.
  upd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_cmd   (wr_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (rd_cmd)
  );

  // Back: serializes each command into output byte transfers.
  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (rd_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ----- design/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// Accepts characters, tracks the escape phase and turns each character into
// a command of zero to three output bytes.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,      // a character is taken this cycle
  input  logic [7:0]       char_i,
  input  logic             last_i,
  output logic             push,
  output upd_pkg::upd_cmd_t cmd
);
  import upd_pkg::*;

  upd_phase_t  phase_r, phase_nxt, phase_mid;
  logic [7:0]  held_r, held_nxt;
  logic        c_hex;
  logic        fresh_emit;
  logic [7:0]  fresh_byte;
  logic [1:0]  n;
  logic [2:0][7:0] b;

  assign c_hex      = is_hex(char_i);
  assign fresh_emit = (char_i != CH_PERCENT);
  assign fresh_byte = (char_i == CH_PLUS) ? CH_SPACE : char_i;

  // Next state.
  always_comb begin
    held_nxt = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (c_hex) begin
          phase_mid = PH_DIGIT;
          held_nxt  = char_i;
        end else begin
          phase_mid = (char_i == CH_PERCENT) ? PH_PCT : PH_IDLE;
        end
      end
      PH_DIGIT: begin
        if (c_hex) begin
          phase_mid = PH_IDLE;
        end else begin
          phase_mid = (char_i == CH_PERCENT) ? PH_PCT : PH_IDLE;
        end
      end
      default: begin
        phase_mid = (char_i == CH_PERCENT) ? PH_PCT : PH_IDLE;
      end
    endcase
    phase_nxt = last_i ? PH_IDLE : phase_mid;
  end

  // Bytes produced by this character.
  always_comb begin
    n = 2'd0;
    b = '0;
    unique case (phase_r)
      PH_PCT: begin
        if (!c_hex) begin
          b[n] = CH_PERCENT;
          n    = n + 2'd1;
          if (fresh_emit) begin
            b[n] = fresh_byte;
            n    = n + 2'd1;
          end
        end
      end
      PH_DIGIT: begin
        if (c_hex) begin
          b[n] = {hex_val(held_r), hex_val(char_i)};
          n    = n + 2'd1;
        end else begin
          b[n] = CH_PERCENT;
          n    = n + 2'd1;
          b[n] = held_r;
          n    = n + 2'd1;
          if (fresh_emit) begin
            b[n] = fresh_byte;
            n    = n + 2'd1;
          end
        end
      end
      default: begin
        if (fresh_emit) begin
          b[n] = fresh_byte;
          n    = n + 2'd1;
        end
      end
    endcase
    // End of string: flush whatever is still held.
    if (last_i) begin
      if (phase_mid == PH_PCT) begin
        b[n] = CH_PERCENT;
        n    = n + 2'd1;
      end else if (phase_mid == PH_DIGIT) begin
        // A digit is held only when this very character was it.
        b[n] = CH_PERCENT;
        n    = n + 2'd1;
        b[n] = char_i;
        n    = n + 2'd1;
      end
    end
  end

  assign cmd.last = last_i;
  assign cmd.cnt  = n;
  assign cmd.data = b;
  assign push     = acc && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- design/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// Small command FIFO that decouples the front classifier from the back.
// ----------------------------------------------------------------------------
module upd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_cmd_t wr_cmd,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output upd_pkg::upd_cmd_t rd_cmd
);
  import upd_pkg::*;

  upd_cmd_t        mem [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QAW:0]    count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == QDEPTH[QAW:0]);
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// Takes commands from the queue and sends their bytes one per cycle while
// out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  upd_pkg::upd_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import upd_pkg::*;

  upd_cmd_t    cur_r;
  logic        cur_valid_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        load;
  logic        done;

  assign load  = cur_valid_r && (!out_valid_r || out_ready);
  assign done  = (idx_r == (cur_r.cnt - 2'd1));
  assign q_pop = q_valid && (!cur_valid_r || (load && done));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (load && done) begin
      cur_valid_r <= 1'b0;
    end else if (load) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_r.data[idx_r];
      out_last_r <= cur_r.last && done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ----- dv/url_percent_decoder_test.sv -----
// ----------------------------------------------------------------------------
// url_percent_decoder_test
// Self-checking testbench for the streaming URL percent decoder.
// ----------------------------------------------------------------------------
// Encoded strings are sent one character per transfer. A behavioral decoder
// in the testbench tracks the escape phase and the held digit, and it queues
// the decoded bytes that each accepted character must produce. A checker
// compares every output transfer with the oldest queued byte. The run goes
// through directed escapes, broken escapes and end-of-string flushes, a
// stretch of full-rate streaming, a long output stall that fills the block,
// and a long random part made mostly of well-formed strings.
// ----------------------------------------------------------------------------
module url_percent_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  // One decoded byte as it must appear on the output channel.
  typedef struct {
    logic [7:0] value;
    logic       last;
  } decoded_byte_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // Bytes that the decoder still owes, oldest first.
  decoded_byte_t expected_bytes[$];

  // Decoder state as the testbench sees it.
  upd_phase_t escape_phase = PH_IDLE;
  logic [7:0] held_digit   = 8'h00;

  int  error_count    = 0;
  int  chars_sent     = 0;
  bit  tx_idle_en     = 1'b1;
  bit  rx_idle_en     = 1'b1;
  bit  long_stall_req = 1'b0;
  int  stall_left     = 0;

  url_percent_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Character helpers for the behavioral decoder.
  // --------------------------------------------------------------------------
  function automatic bit char_is_hex(input logic [7:0] c);
    bit hex;
    hex = 1'b0;
    if (c >= "0" && c <= "9") hex = 1'b1;
    if (c >= "A" && c <= "F") hex = 1'b1;
    if (c >= "a" && c <= "f") hex = 1'b1;
    return hex;
  endfunction

  function automatic logic [3:0] char_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "a")      v = c - "a" + 8'd10;
    else if (c >= "A") v = c - "A" + 8'd10;
    else               v = c - "0";
    return v[3:0];
  endfunction

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    // Mix both letter cases.
    return $urandom_range(1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] random_plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (char_is_hex(c));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Behavioral decoder: queues the bytes that one accepted character causes.
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, inout int n);
    decoded_byte_t d;
    d.value = b;
    d.last  = 1'b0;
    expected_bytes.push_back(d);
    n++;
  endtask

  // A character seen with nothing held: a percent sign opens an escape.
  task automatic decode_plain(input logic [7:0] c, inout int n);
    if (c == CH_PERCENT) escape_phase = PH_PCT;
    else if (c == CH_PLUS) queue_byte(CH_SPACE, n);
    else queue_byte(c, n);
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    int n;
    n = 0;
    case (escape_phase)
      PH_PCT: begin
        if (char_is_hex(c)) begin
          held_digit   = c;
          escape_phase = PH_DIGIT;
        end else begin
          // The escape is broken: the percent goes out, and the breaking
          // character starts over, possibly as a new escape.
          escape_phase = PH_IDLE;
          queue_byte(CH_PERCENT, n);
          decode_plain(c, n);
        end
      end
      PH_DIGIT: begin
        escape_phase = PH_IDLE;
        if (char_is_hex(c)) begin
          queue_byte({char_nibble(held_digit), char_nibble(c)}, n);
        end else begin
          queue_byte(CH_PERCENT, n);
          queue_byte(held_digit, n);
          decode_plain(c, n);
        end
        held_digit = 8'h00;
      end
      default: begin
        escape_phase = PH_IDLE;
        decode_plain(c, n);
      end
    endcase
    if (last) begin
      // Whatever is still held is flushed at the end of the string.
      if (escape_phase == PH_PCT) begin
        queue_byte(CH_PERCENT, n);
      end else if (escape_phase == PH_DIGIT) begin
        queue_byte(CH_PERCENT, n);
        queue_byte(held_digit, n);
      end
      escape_phase = PH_IDLE;
      held_digit   = 8'h00;
      if (n > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: offers one character at a falling edge and holds it until the
  // transfer. The task is entered and left at a falling edge, so a character
  // that follows without a gap keeps in_tvalid high throughout.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic last);
    while (tx_idle_en && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    decode_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Sends one random string, mostly well-formed with random content.
  task automatic send_random_string();
    logic [7:0] chars[$];
    int         parts;
    int         pick;
    bit         noise;
    chars = {};
    parts = $urandom_range(1, 8);
    noise = ($urandom_range(99) < 15);
    for (int p = 0; p < parts; p++) begin
      pick = noise ? 99 : $urandom_range(99);
      if (pick < 40) begin
        chars.push_back(CH_PERCENT);
        chars.push_back(random_hex_char());
        chars.push_back(random_hex_char());
      end else if (pick < 55) begin
        chars.push_back(CH_PLUS);
      end else if (pick < 70) begin
        // Broken escapes: cut after the percent or after one digit, either
        // by an ordinary character, a plus, a new percent or the string end.
        chars.push_back(CH_PERCENT);
        if ($urandom_range(1)) chars.push_back(random_hex_char());
        case ($urandom_range(3))
          0: chars.push_back(random_plain_char());
          1: chars.push_back(CH_PLUS);
          2: chars.push_back(CH_PERCENT);
          default: ;
        endcase
      end else begin
        chars.push_back(8'($urandom_range(1, 255)));
      end
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request that lets the
  // command queue fill and stop the input side.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = 80;
        out_tready     <= 1'b0;
      end else begin
        out_tready <= !(rx_idle_en && $urandom_range(99) < 14);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every output transfer against the oldest queued byte.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (error_count < 40) $display("%0t ns: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    decoded_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %h with nothing expected", out_tdata));
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.value)
          report_mismatch($sformatf("byte %h, expected %h", out_tdata, want.value));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b on byte %h",
                                    out_tlast, want.last, want.value));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Field extremes, each escape form and several ways an escape can break.
  task automatic test_directed();
    send_char(8'h01, 1'b0);        // lowest character passes through
    send_char(8'hFF, 1'b0);        // highest character passes through
    send_char(CH_PLUS, 1'b1);      // plus becomes a space and ends the string
    send_string("%4a");            // a lowercase hex letter
    send_string("%fF");            // highest decoded byte
    send_string("%00");            // lowest decoded byte
    send_string("%4g");            // broken with a digit held: three bytes
    send_string("%%4");            // broken by a new percent, then flushed
    send_string("%4%");            // digit held, broken by a percent, flushed
    send_string("%4+");            // broken by a plus, which still decodes
  endtask

  // Back-to-back characters with neither side idling.
  task automatic test_full_rate(input int count);
    int stop;
    stop       = chars_sent + count;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (chars_sent < stop) send_random_string();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The output holds off for a long stretch while characters keep coming.
  task automatic test_output_stall(input int count);
    int stop;
    stop           = chars_sent + count;
    tx_idle_en     = 1'b0;
    long_stall_req = 1'b1;
    while (chars_sent < stop) send_random_string();
    tx_idle_en     = 1'b1;
  endtask

  task automatic test_random(input int count);
    int stop;
    stop = chars_sent + count;
    while (chars_sent < stop) send_random_string();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_rate(100);
    test_output_stall(40);
    test_random(300);

    // send_char returns at a falling edge, so the valid drops cleanly here.
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // Wait on so that a stray extra byte would still be seen.
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
